@@ rtl/assert_macros.svh @@
// Assertion macros used by the demodulator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising edge of an explicit clock, off while in reset
`define WPD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property on the block clock and reset
`define WPD_ASSERT(lbl, prop, msg) \
  `WPD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/wpd_pkg.sv @@
// Types and constants shared by the Walsh 8-PAM symbol demodulator
package wpd_pkg;

  localparam int unsigned SampleW        = 12;
  localparam int unsigned NumChips       = 4;
  localparam int unsigned SamplesPerChip = 3;
  localparam int unsigned NumThresh      = 28;
  localparam int unsigned CountW         = 5;
  localparam int unsigned SymbolW        = 12;
  localparam int unsigned DigitW         = 3;

  localparam logic [SymbolW-1:0] SyncWord = 12'h96D;

  typedef logic [SampleW-1:0] sample_t;
  typedef sample_t [NumThresh-1:0] thr_vec_t;
  typedef sample_t [SamplesPerChip-1:0] chip_samples_t;
  typedef logic [CountW-1:0] level_count_t;

  typedef enum logic [0:0] {
    CfgLowLevel  = 1'b0,
    CfgHighLevel = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    sample_t chip0_sample0;
    sample_t chip0_sample1;
    sample_t chip0_sample2;
    sample_t chip1_sample0;
    sample_t chip1_sample1;
    sample_t chip1_sample2;
    sample_t chip2_sample0;
    sample_t chip2_sample1;
    sample_t chip2_sample2;
    sample_t chip3_sample0;
    sample_t chip3_sample1;
    sample_t chip3_sample2;
  } window_t;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               sync_match;
  } result_t;

endpackage

@@ rtl/wpd_thresh_gen.sv @@
// Threshold table generator: 28 quantizer thresholds from the calibration levels
module wpd_thresh_gen import wpd_pkg::*; (
  input  logic     clk_i,
  input  sample_t  low_level_i,
  input  sample_t  high_level_i,
  output thr_vec_t thr_o
);

  localparam int unsigned ProdW     = 2 * SampleW;
  localparam int unsigned QuotW     = SampleW + 1;
  localparam logic [ProdW:0] FullScale = (ProdW+1)'(4095);

  function automatic sample_t thr_base(int unsigned k);
    return SampleW'(77 + 141 * k);
  endfunction

  sample_t              lo_d, lo_q, range_d;
  logic [ProdW-1:0]     p_d [NumThresh];
  logic [ProdW-1:0]     p_q [NumThresh];
  thr_vec_t             thr_d, thr_q;

  always_comb begin
    if (low_level_i > high_level_i) begin
      lo_d    = high_level_i;
      range_d = low_level_i - high_level_i;
    end else begin
      lo_d    = low_level_i;
      range_d = high_level_i - low_level_i;
    end
    for (int unsigned k = 0; k < NumThresh; k++) begin
      p_d[k] = {{SampleW{1'b0}}, range_d} * {{SampleW{1'b0}}, thr_base(k)};
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    p_q  <= p_d;
  end

  // floor(p / 4095): estimate, then one correction step
  always_comb begin
    logic [ProdW:0]  est;
    logic [QuotW-1:0] q0;
    logic [ProdW:0]  rem;
    logic [QuotW-1:0] q;
    for (int unsigned k = 0; k < NumThresh; k++) begin
      est = {1'b0, p_q[k]} + {{(QuotW){1'b0}}, p_q[k][ProdW-1:SampleW]};
      q0  = est[ProdW:SampleW];
      rem = {1'b0, p_q[k]} - {q0, {SampleW{1'b0}}} + {{SampleW{1'b0}}, q0};
      q   = q0 + QuotW'(rem >= FullScale);
      thr_d[k] = lo_q + q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
  end

  assign thr_o = thr_q;

endmodule

@@ rtl/wpd_chip_lane.sv @@
// Per-chip lane: robust three-sample mean and threshold quantization
module wpd_chip_lane import wpd_pkg::*; (
  input  logic          clk_i,
  input  chip_samples_t samples_i,
  input  thr_vec_t      thr_i,
  output level_count_t  count_o
);

  localparam int unsigned SumW   = SampleW + 2;
  localparam int unsigned RecipW = 16;
  localparam int unsigned RecipSh = 17;
  localparam logic [RecipW-1:0] Recip3 = RecipW'(43691);
  localparam int unsigned GroupSz = 7;
  localparam int unsigned NumGroups = NumThresh / GroupSz;

  chip_samples_t          s_q, t_q;
  logic [SumW-1:0]        sum_d, sum_q;
  logic [SumW+RecipW-1:0] prod;
  sample_t                mean_d, mean_q;
  sample_t                rmean_d, rmean_q;
  level_count_t           count_d, count_q;

  always_ff @(posedge clk_i) begin
    s_q <= samples_i;
  end

  always_comb begin
    sum_d = SumW'(s_q[0]) + SumW'(s_q[1]) + SumW'(s_q[2]);
    prod  = {{RecipW{1'b0}}, sum_d} * {{SumW{1'b0}}, Recip3};
    mean_d = prod[RecipSh +: SampleW];
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    mean_q <= mean_d;
    t_q    <= s_q;
  end

  // drop the earliest sample with the largest deviation, average the rest
  always_comb begin
    sample_t         dev [SamplesPerChip];
    sample_t         max_dev;
    sample_t         dropped;
    logic [SumW-1:0] rest;
    for (int unsigned i = 0; i < SamplesPerChip; i++) begin
      dev[i] = (t_q[i] > mean_q) ? (t_q[i] - mean_q) : (mean_q - t_q[i]);
    end
    max_dev = dev[0];
    dropped = t_q[0];
    for (int unsigned i = 1; i < SamplesPerChip; i++) begin
      if (dev[i] > max_dev) begin
        max_dev = dev[i];
        dropped = t_q[i];
      end
    end
    rest    = sum_q - SumW'(dropped);
    rmean_d = rest[SampleW:1];
  end

  always_ff @(posedge clk_i) begin
    rmean_q <= rmean_d;
  end

  always_comb begin
    level_count_t part [NumGroups];
    count_d = '0;
    for (int unsigned g = 0; g < NumGroups; g++) begin
      part[g] = '0;
      for (int unsigned k = 0; k < GroupSz; k++) begin
        part[g] = part[g] + CountW'(rmean_q >= thr_i[g*GroupSz + k]);
      end
      count_d = count_d + part[g];
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign count_o = count_q;

endmodule

@@ rtl/wpd_walsh_merge.sv @@
// Merge stage: inverse Walsh transform of the chip levels, slicing and packing
module wpd_walsh_merge import wpd_pkg::*; (
  input  logic         clk_i,
  input  level_count_t counts_i [NumChips],
  output result_t      result_o
);

  localparam int unsigned AccW = 9;
  localparam int unsigned EstW = 7;
  localparam logic [NumChips-1:0] HadNeg [NumChips] = '{4'b0000, 4'b1100, 4'b0110, 4'b1010};

  function automatic logic [DigitW-1:0] slice3(logic signed [EstW-1:0] v);
    logic [DigitW-1:0] d;
    priority if (v <= -EstW'(6)) d = 3'd0;
    else if (v <= -EstW'(4))     d = 3'd1;
    else if (v <= -EstW'(2))     d = 3'd2;
    else if (v < EstW'(0))       d = 3'd3;
    else if (v < EstW'(2))       d = 3'd4;
    else if (v < EstW'(4))       d = 3'd5;
    else if (v < EstW'(6))       d = 3'd6;
    else                         d = 3'd7;
    return d;
  endfunction

  result_t result_d, result_q;

  always_comb begin
    logic signed [AccW-1:0] lvl [NumChips];
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] sh;
    logic [SymbolW-1:0]     sym;
    for (int unsigned j = 0; j < NumChips; j++) begin
      lvl[j] = $signed({3'b000, counts_i[j], 1'b0}) - AccW'(28);
    end
    sym = '0;
    for (int unsigned i = 0; i < NumChips; i++) begin
      acc = '0;
      for (int unsigned j = 0; j < NumChips; j++) begin
        if (HadNeg[i][j]) acc = acc - lvl[j];
        else              acc = acc + lvl[j];
      end
      sh = acc >>> 2;
      sym[DigitW*(NumChips-1-i) +: DigitW] = slice3(sh[EstW-1:0]);
    end
    result_d.symbol     = sym;
    result_d.sync_match = (sym == SyncWord);
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

@@ rtl/walsh_pam8_symbol_demodulator.sv @@
// Walsh 4-chip 8-PAM symbol demodulator top level
// One symbol window is taken in every clock cycle and busy never rises; each
// result appears with result_valid_o for a single cycle. Four chip lanes
// (input capture, sum and divide by three, outlier drop, threshold count) feed a
// merge stage that runs the inverse Walsh transform and packs the symbol; the
// five register stages of that path set the latency. The threshold table follows
// a write to low_level or high_level through its product and threshold
// registers, so windows may follow a write at once.
`include "assert_macros.svh"
module walsh_pam8_symbol_demodulator import wpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  window_t  item_i,
  output logic     result_valid_o,
  output result_t  result_o,
  input  logic     cfg_we_i,
  input  cfg_reg_e cfg_idx_i,
  input  sample_t  cfg_wdata_i
);

  localparam int unsigned ResultLatency = 5;

  sample_t       low_q, high_q;
  thr_vec_t      thr;
  chip_samples_t lane_samples [NumChips];
  level_count_t  lane_counts [NumChips];
  logic [ResultLatency-1:0] vld_q;
  logic          accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLowLevel:  low_q  <= cfg_wdata_i;
        CfgHighLevel: high_q <= cfg_wdata_i;
        default:      low_q  <= low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ResultLatency-2:0], accept};
    end
  end

  assign lane_samples[0] = {item_i.chip0_sample2, item_i.chip0_sample1, item_i.chip0_sample0};
  assign lane_samples[1] = {item_i.chip1_sample2, item_i.chip1_sample1, item_i.chip1_sample0};
  assign lane_samples[2] = {item_i.chip2_sample2, item_i.chip2_sample1, item_i.chip2_sample0};
  assign lane_samples[3] = {item_i.chip3_sample2, item_i.chip3_sample1, item_i.chip3_sample0};

  wpd_thresh_gen u_thresh_gen (
    .clk_i        (clk_i),
    .low_level_i  (low_q),
    .high_level_i (high_q),
    .thr_o        (thr)
  );

  for (genvar j = 0; j < NumChips; j++) begin : g_lane
    wpd_chip_lane u_lane (
      .clk_i     (clk_i),
      .samples_i (lane_samples[j]),
      .thr_i     (thr),
      .count_o   (lane_counts[j])
    );
  end

  wpd_walsh_merge u_merge (
    .clk_i    (clk_i),
    .counts_i (lane_counts),
    .result_o (result_o)
  );

  assign result_valid_o = vld_q[ResultLatency-1];

  `WPD_ASSERT(a_result_has_source, result_valid_o |-> $past(start && !busy, ResultLatency), "result without a transaction")
  `WPD_ASSERT(a_transaction_yields, (start && !busy) |-> ##ResultLatency result_valid_o, "transaction lost")
  `WPD_ASSERT(a_sync_flag, result_valid_o |-> (result_o.sync_match == (result_o.symbol == SyncWord)), "sync flag mismatch")

endmodule
